// ===== src/deq_pkg.sv =====
// Package for the double-ended queue: sizes, command codes, state type and index helper.
package deq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned OccW  = 5;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [CmdW-1:0] {
    CmdPushBack  = CmdW'(0),
    CmdPushFront = CmdW'(1),
    CmdPopFront  = CmdW'(2),
    CmdPopBack   = CmdW'(3)
  } deq_cmd_e;

  typedef enum logic {
    StIdle = 1'b0,
    StRead = 1'b1
  } deq_state_e;

  // The base is below Depth and the offset at most Depth, so one subtraction wraps the sum.
  function automatic idx_t wrap_add(idx_t base, cnt_t offset);
    logic [CntW:0] sum;
    sum = (CntW + 1)'(base) + (CntW + 1)'(offset);
    if (sum >= (CntW + 1)'(Depth)) begin
      sum = sum - (CntW + 1)'(Depth);
    end
    return IdxW'(sum);
  endfunction

endpackage

// ===== src/deq_ram.sv =====
// Generic single-port RAM with a registered read.
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                       wdata_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue held in a circular RAM.
//
// A bounded double-ended queue of signed 32-bit words. Each command word pushes at the
// back or front, or pops from the front or back, and gives exactly one result word with
// the popped value, an error flag, an empty flag and the occupancy after the command.
// A push, or any command that fails, is answered from the idle state; a pop that
// removes an entry passes through the read state, because the single-port RAM's read
// is registered. A pop on an empty queue or a push on a full one leaves the queue
// unchanged, returns zero and sets the error flag. A finished result waits in an output
// register, and a new command is taken in the cycle that result is taken. Entries need
// no clearing after reset, since only written entries are ever read.
module double_ended_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [deq_pkg::CmdW-1:0]            command_i,
  input  logic signed [deq_pkg::DataW-1:0]    push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [deq_pkg::DataW-1:0]    pop_value_o,
  output logic                                error_o,
  output logic                                now_empty_o,
  output logic [deq_pkg::OccW-1:0]            occupancy_o
);

  deq_pkg::deq_state_e state_q, state_d;
  deq_pkg::idx_t       front_q, front_d;
  deq_pkg::cnt_t       count_q, count_d;

  logic                       out_valid_q, out_valid_d;
  logic [deq_pkg::DataW-1:0]  pop_value_q;
  logic                       error_q;
  logic                       now_empty_q;
  logic [deq_pkg::OccW-1:0]   occupancy_q;

  logic                       accept;
  logic                       is_full;
  logic                       is_empty;
  logic                       op_err;
  logic                       op_read;
  logic                       load_now;
  logic                       load_pop;
  logic                       ram_we;
  deq_pkg::idx_t              ram_addr;
  logic [deq_pkg::DataW-1:0]  ram_rdata;

  assign in_ready_o = (state_q == deq_pkg::StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == deq_pkg::CntW'(deq_pkg::Depth));
  assign is_empty   = (count_q == '0);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    ram_we   = 1'b0;
    ram_addr = front_q;
    op_err   = 1'b0;
    op_read  = 1'b0;
    if (accept) begin
      case (deq_pkg::deq_cmd_e'(command_i))
        deq_pkg::CmdPushBack: begin
          if (is_full) begin
            op_err = 1'b1;
          end else begin
            ram_addr = deq_pkg::wrap_add(front_q, count_q);
            ram_we   = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        deq_pkg::CmdPushFront: begin
          if (is_full) begin
            op_err = 1'b1;
          end else begin
            front_d  = deq_pkg::wrap_add(front_q, deq_pkg::CntW'(deq_pkg::Depth - 1));
            ram_addr = front_d;
            ram_we   = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        deq_pkg::CmdPopFront: begin
          if (is_empty) begin
            op_err = 1'b1;
          end else begin
            ram_addr = front_q;
            op_read  = 1'b1;
            front_d  = deq_pkg::wrap_add(front_q, deq_pkg::CntW'(1));
            count_d  = count_q - 1'b1;
          end
        end
        deq_pkg::CmdPopBack: begin
          if (is_empty) begin
            op_err = 1'b1;
          end else begin
            ram_addr = deq_pkg::wrap_add(front_q, count_q - 1'b1);
            op_read  = 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        default: begin
          op_err = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    load_now = 1'b0;
    load_pop = 1'b0;
    case (state_q)
      deq_pkg::StIdle: begin
        if (accept) begin
          if (op_read) begin
            state_d = deq_pkg::StRead;
          end else begin
            load_now = 1'b1;
          end
        end
      end
      deq_pkg::StRead: begin
        load_pop = 1'b1;
        state_d  = deq_pkg::StIdle;
      end
      default: begin
        state_d = deq_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_now || load_pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::StIdle;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      error_q     <= op_err;
      now_empty_q <= (count_d == '0);
      occupancy_q <= deq_pkg::OccW'(count_d);
    end
    if (load_now) begin
      pop_value_q <= '0;
    end else if (load_pop) begin
      pop_value_q <= ram_rdata;
    end
  end

  deq_ram #(
    .Width (deq_pkg::DataW),
    .Depth (deq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (push_value_i),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign pop_value_o = pop_value_q;
  assign error_o     = error_q;
  assign now_empty_o = now_empty_q;
  assign occupancy_o = occupancy_q;

endmodule

// ===== src/deq_checker.sv =====
// Port-level checker for the double-ended queue, bound to the top level.
module deq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [deq_pkg::CmdW-1:0]          command_i,
  input logic signed [deq_pkg::DataW-1:0]  push_value_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [deq_pkg::DataW-1:0]  pop_value_o,
  input logic                              error_o,
  input logic                              now_empty_o,
  input logic [deq_pkg::OccW-1:0]          occupancy_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ (|command_i) ^ (|push_value_i);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (pop_value_o == '0))
    else $error("An error word carries a non-zero value.");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (now_empty_o == (occupancy_o == '0)))
    else $error("Empty flag disagrees with occupancy.");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(occupancy_o) <= 32'(deq_pkg::Depth)))
    else $error("Occupancy exceeds the queue depth.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pop_value_o)
      && $stable(error_o) && $stable(occupancy_o)))
    else $error("A stalled result word changed.");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("A command word was taken while a result word was stalled.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// ===== tb/sv/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the double-ended queue: directed and random command words checked against a predictor.
module double_ended_queue_tb;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 150;

  typedef struct packed {
    logic signed [deq_pkg::DataW-1:0] pop_value;
    logic                             error;
    logic                             now_empty;
    logic [deq_pkg::OccW-1:0]         occupancy;
  } deque_result_t;

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_ready_o;
  logic [deq_pkg::CmdW-1:0]         command_i    = '0;
  logic signed [deq_pkg::DataW-1:0] push_value_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i  = 1'b0;
  logic signed [deq_pkg::DataW-1:0] pop_value_o;
  logic                             error_o;
  logic                             now_empty_o;
  logic [deq_pkg::OccW-1:0]         occupancy_o;

  logic [deq_pkg::DataW-1:0] model_store [deq_pkg::Depth];
  int unsigned               model_front;
  int unsigned               model_count;

  deque_result_t expected_results [$];
  deque_result_t oldest_result;
  int unsigned   fail_count  = 0;
  int unsigned   quiet_count = 0;
  int unsigned   hold_left   = 0;
  bit            hold_req    = 1'b0;
  bit            tx_idle_on  = 1'b1;
  bit            rx_idle_on  = 1'b1;

  double_ended_queue i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pop_value_o  (pop_value_o),
    .error_o      (error_o),
    .now_empty_o  (now_empty_o),
    .occupancy_o  (occupancy_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic deque_result_t apply_command(deq_pkg::deq_cmd_e cmd,
                                                  logic [deq_pkg::DataW-1:0] value);
    deque_result_t res;
    res = '0;
    case (cmd)
      deq_pkg::CmdPushBack: begin
        if (model_count >= deq_pkg::Depth) begin
          res.error = 1'b1;
        end else begin
          model_store[(model_front + model_count) % deq_pkg::Depth] = value;
          model_count++;
        end
      end
      deq_pkg::CmdPushFront: begin
        if (model_count >= deq_pkg::Depth) begin
          res.error = 1'b1;
        end else begin
          model_front = (model_front + deq_pkg::Depth - 1) % deq_pkg::Depth;
          model_store[model_front] = value;
          model_count++;
        end
      end
      deq_pkg::CmdPopFront: begin
        if (model_count == 0) begin
          res.error = 1'b1;
        end else begin
          res.pop_value = model_store[model_front];
          model_front = (model_front + 1) % deq_pkg::Depth;
          model_count--;
        end
      end
      default: begin
        if (model_count == 0) begin
          res.error = 1'b1;
        end else begin
          res.pop_value = model_store[(model_front + model_count - 1) % deq_pkg::Depth];
          model_count--;
        end
      end
    endcase
    res.now_empty = (model_count == 0);
    res.occupancy = deq_pkg::OccW'(model_count);
    return res;
  endfunction

  // Offers one command word and records its expected result once it is taken.
  task automatic send_word(deq_pkg::deq_cmd_e cmd, logic [deq_pkg::DataW-1:0] value);
    if (tx_idle_on) begin
      while ($urandom_range(99) < 14) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    push_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    expected_results.push_back(apply_command(cmd, value));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_random_word(int unsigned push_pct);
    deq_pkg::deq_cmd_e cmd;
    if ($urandom_range(99) < push_pct) begin
      cmd = $urandom_range(1) ? deq_pkg::CmdPushFront : deq_pkg::CmdPushBack;
    end else begin
      cmd = $urandom_range(1) ? deq_pkg::CmdPopFront : deq_pkg::CmdPopBack;
    end
    send_word(cmd, $urandom);
  endtask

  task automatic test_edge_values();
    send_word(deq_pkg::CmdPopFront, 32'h0);
    send_word(deq_pkg::CmdPopBack, 32'hffff_ffff);
    send_word(deq_pkg::CmdPushBack, 32'h7fff_ffff);
    send_word(deq_pkg::CmdPushFront, 32'h8000_0000);
    send_word(deq_pkg::CmdPushBack, 32'h0);
    send_word(deq_pkg::CmdPushFront, 32'hffff_ffff);
    send_word(deq_pkg::CmdPopBack, $urandom);
    send_word(deq_pkg::CmdPopFront, $urandom);
    send_word(deq_pkg::CmdPopFront, $urandom);
    send_word(deq_pkg::CmdPopBack, $urandom);
    send_word(deq_pkg::CmdPopFront, $urandom);
  endtask

  // Fills the queue with pushes at both ends, so the front index wraps, then pushes on full.
  task automatic test_full_queue();
    for (int i = 0; i < deq_pkg::Depth; i++) begin
      send_word((i % 3 == 0) ? deq_pkg::CmdPushBack : deq_pkg::CmdPushFront, $urandom);
    end
    send_word(deq_pkg::CmdPushBack, $urandom);
    send_word(deq_pkg::CmdPushFront, $urandom);
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_random_word(50);
    end
  endtask

  task automatic test_sender_pause();
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_random_word(60);
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < 250; i++) begin
      send_random_word(50);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Blocks of commands leaning towards pushes or pops sweep the occupancy between empty and full.
  task automatic test_random_traffic();
    int unsigned bias [4] = '{15, 50, 85, 97};
    int unsigned push_pct;
    for (int blk = 0; blk < 45; blk++) begin
      push_pct = bias[$urandom_range(3)];
      for (int i = 0; i < 40; i++) begin
        send_random_word(push_pct);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_idle_on) begin
      out_ready_i <= ($urandom_range(99) >= 14);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with no command pending");
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (pop_value_o !== oldest_result.pop_value) begin
          $error("pop_value: expected %0d, actual %0d", oldest_result.pop_value, pop_value_o);
          fail_count++;
        end
        if (error_o !== oldest_result.error) begin
          $error("error: expected %0b, actual %0b", oldest_result.error, error_o);
          fail_count++;
        end
        if (now_empty_o !== oldest_result.now_empty) begin
          $error("now_empty: expected %0b, actual %0b", oldest_result.now_empty, now_empty_o);
          fail_count++;
        end
        if (occupancy_o !== oldest_result.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", oldest_result.occupancy, occupancy_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_count = 0;
    end else if (rst_ni) begin
      quiet_count++;
    end
    if (quiet_count >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    model_front = 0;
    model_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_values();
    test_full_queue();
    test_output_stall();
    test_sender_pause();
    test_back_to_back();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
